>>> hdl/stu_pkg.sv
// Shared constants, types and helpers for the scanline triangle unit.
// No dependencies.
package stu_pkg;

	localparam int SCR_W  = 320;
	localparam int SCR_H  = 240;
	localparam int FRAC   = 16;
	localparam int FX_W   = 32;
	localparam int DVD_W  = 27;
	localparam int DVS_W  = 11;
	localparam int CNT_W  = 10;
	localparam int SPAN_W = 11;
	localparam int CRD_W  = 12;

	localparam logic signed [FX_W-1:0] FX_ONE  = FX_W'(1) <<< FRAC;
	localparam logic signed [FX_W-1:0] FX_HALF = FX_W'(1) <<< (FRAC - 1);
	localparam logic [7:0] ALPHA = 8'hFF;

	typedef enum logic [1:0] {SEL_SPLIT, SEL_S0, SEL_S1, SEL_SY} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     enter;
		logic     half_bot;
		logic     start_row;
		logic     next_row;
		logic     pixel;
	} cmd_t;

	typedef struct packed {
		logic flat;
		logic div_done;
		logic n_zero;
		logic span_left;
		logic row_more;
	} sts_t;

	function automatic logic signed [FX_W-1:0] round_fx(input logic signed [FX_W-1:0] v);
		logic signed [FX_W-1:0] r;
		if (v >= 0) begin
			r = (v + FX_HALF) >>> FRAC;
		end else begin
			r = -((-v + FX_HALF) >>> FRAC);
		end
		return r;
	endfunction

endpackage

>>> hdl/stu_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on stu_pkg.
module stu_div
	import stu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;

	assign shifted  = {rem_q, q_q[DVD_W-1]};
	assign trial    = {1'b0, shifted} - {2'b0, dvs_q};
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W-1:0];
				q_q   <= {q_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				q_q   <= {q_q[DVD_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> hdl/stu_datapath.sv
// Vertex, edge, row and span registers with the fixed-point DDA arithmetic.
// Depends on stu_pkg and stu_div.
module stu_datapath
	import stu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [8:0]  ax,
	input  logic [7:0]  ay,
	input  logic [8:0]  bx,
	input  logic [7:0]  by_coord,
	input  logic [8:0]  cx,
	input  logic [7:0]  cy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic [8:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [31:0] pixel_argb
);

	logic [8:0]  tx_q, mx_q, bvx_q;
	logic [7:0]  ty_q, my_q, bvy_q;
	logic [23:0] colour_q;
	logic signed [CRD_W-1:0] split_q, d0_q, d1_q, dy_q;
	logic [CNT_W-1:0]  n_q, row_cnt_q;
	logic signed [FX_W-1:0] s0_q, s1_q, sy_q;
	logic signed [FX_W-1:0] from_q, to_q, yacc_q, curx_q;
	logic              dir_q;
	logic [SPAN_W-1:0] span_cnt_q, span_num_q;
	logic [8:0]        px_q;
	logic [7:0]        py_q;
	div_sel_t          sel_q;

	logic [8:0] sx0, sx1, sx2;
	logic [7:0] sy0, sy1, sy2;
	logic signed [CRD_W-1:0] e0, e1, ey, a0, a1, ay_abs, nmax;
	logic signed [CRD_W-1:0] ty_s, my_s, by_s, tx_s, mx_s, bx_s;
	logic signed [2*CRD_W-1:0] num;
	logic [DVD_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic signed [CRD_W-1:0] dsel;
	logic             div_done;
	logic [DVD_W-1:0] quot;
	logic signed [FX_W-1:0] qs, diff, mag, rx, ry;

	assign tx_s = CRD_W'(tx_q);
	assign mx_s = CRD_W'(mx_q);
	assign bx_s = CRD_W'(bvx_q);
	assign ty_s = CRD_W'(ty_q);
	assign my_s = CRD_W'(my_q);
	assign by_s = CRD_W'(bvy_q);

	always_comb begin
		if (ay >= by_coord && by_coord >= cy) begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {ax, ay, bx, by_coord, cx, cy};
		end else if (ay >= cy && cy >= by_coord) begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {ax, ay, cx, cy, bx, by_coord};
		end else if (by_coord >= ay && ay >= cy) begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {bx, by_coord, ax, ay, cx, cy};
		end else if (by_coord >= cy && cy >= ay) begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {bx, by_coord, cx, cy, ax, ay};
		end else if (cy >= ay && ay >= by_coord) begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {cx, cy, ax, ay, bx, by_coord};
		end else begin
			{sx2, sy2, sx1, sy1, sx0, sy0} = {cx, cy, bx, by_coord, ax, ay};
		end
	end

	always_comb begin
		if (!cmd.half_bot) begin
			e0 = tx_s - mx_s;
			e1 = tx_s - split_q;
			ey = my_s - ty_s;
		end else begin
			e0 = split_q - bx_s;
			e1 = mx_s - bx_s;
			ey = by_s - my_s;
		end
		a0     = e0 < 0 ? -e0 : e0;
		a1     = e1 < 0 ? -e1 : e1;
		ay_abs = ey < 0 ? -ey : ey;
		nmax   = a0;
		if (a1 > nmax) nmax = a1;
		if (ay_abs > nmax) nmax = ay_abs;
	end

	assign num = (my_s - ty_s) * (bx_s - tx_s);

	always_comb begin
		case (cmd.div_sel)
			SEL_S0:  dsel = d0_q;
			SEL_S1:  dsel = d1_q;
			default: dsel = dy_q;
		endcase
		if (cmd.div_sel == SEL_SPLIT) begin
			dvs = DVS_W'(bvy_q - ty_q);
			if (num < 0) begin
				dvd = DVD_W'(-num) + DVD_W'(bvy_q - ty_q) - DVD_W'(1);
			end else begin
				dvd = DVD_W'(num);
			end
		end else begin
			dvs = {n_q, 1'b0};
			dvd = (DVD_W'(dsel < 0 ? -dsel : dsel) << (FRAC + 1)) + DVD_W'(n_q);
		end
	end

	stu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		case (sel_q)
			SEL_S0:    qs = d0_q < 0 ? -FX_W'(quot) : FX_W'(quot);
			SEL_S1:    qs = d1_q < 0 ? -FX_W'(quot) : FX_W'(quot);
			SEL_SY:    qs = dy_q < 0 ? -FX_W'(quot) : FX_W'(quot);
			default:   qs = num < 0 ? -FX_W'(quot) : FX_W'(quot);
		endcase
		diff = to_q - from_q;
		mag  = diff < 0 ? -diff : diff;
		rx   = round_fx(curx_q);
		ry   = round_fx(yacc_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q     <= sx0;
			ty_q     <= sy0;
			mx_q     <= sx1;
			my_q     <= sy1;
			bvx_q    <= sx2;
			bvy_q    <= sy2;
			colour_q <= {red, green, blue};
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			case (sel_q)
				SEL_S0:  s0_q <= qs;
				SEL_S1:  s1_q <= qs;
				SEL_SY:  sy_q <= qs;
				default: split_q <= tx_s + CRD_W'(qs);
			endcase
		end
		if (cmd.enter) begin
			d0_q       <= e0;
			d1_q       <= e1;
			dy_q       <= ey;
			n_q        <= CNT_W'(nmax);
			row_cnt_q  <= '0;
			span_cnt_q <= '0;
			span_num_q <= '0;
			if (!cmd.half_bot) begin
				from_q <= FX_W'(tx_s) <<< FRAC;
				to_q   <= FX_W'(tx_s) <<< FRAC;
				yacc_q <= FX_W'(ty_s) <<< FRAC;
			end else begin
				from_q <= FX_W'(split_q) <<< FRAC;
				to_q   <= FX_W'(mx_s) <<< FRAC;
				yacc_q <= FX_W'(my_s) <<< FRAC;
			end
		end
		if (cmd.start_row) begin
			curx_q     <= from_q;
			dir_q      <= diff < 0;
			span_cnt_q <= '0;
			span_num_q <= SPAN_W'((mag + FX_ONE - 1) >>> FRAC);
		end
		if (cmd.next_row) begin
			row_cnt_q <= row_cnt_q + CNT_W'(1);
			from_q    <= from_q - s0_q;
			to_q      <= to_q - s1_q;
			yacc_q    <= yacc_q + sy_q;
		end
		if (cmd.pixel) begin
			px_q       <= rx < 0 ? 9'd0 : (rx > FX_W'(SCR_W - 1) ? 9'(SCR_W - 1) : rx[8:0]);
			py_q       <= ry < 0 ? 8'd0 : (ry > FX_W'(SCR_H - 1) ? 8'(SCR_H - 1) : ry[7:0]);
			curx_q     <= dir_q ? curx_q - FX_ONE : curx_q + FX_ONE;
			span_cnt_q <= span_cnt_q + SPAN_W'(1);
		end
	end

	assign sts.flat      = (bvy_q == ty_q);
	assign sts.div_done  = div_done;
	assign sts.n_zero    = (n_q == '0);
	assign sts.span_left = (span_cnt_q < span_num_q);
	assign sts.row_more  = ({1'b0, row_cnt_q} + (CNT_W+1)'(1) < {1'b0, n_q});

	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign pixel_argb = {ALPHA, colour_q};

endmodule

>>> hdl/stu_ctrl.sv
// Sequencer for triangle set-up, half entry, row start and pixel seek.
// Depends on stu_pkg.
module stu_ctrl
	import stu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	output logic out_valid,
	output logic out_last,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RUN, ST_SORT, ST_SPLIT_GO, ST_SPLIT_WAIT, ST_ENTER,
		ST_DIV_GO, ST_DIV_WAIT, ST_ROW, ST_NEXT, ST_SEEK
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	logic       bot_q;
	logic       pend_q;
	logic       valid_q;
	logic       last_q;
	logic       acc;
	div_sel_t   ksel;

	assign in_ready  = (state_q == ST_IDLE || state_q == ST_RUN) && (!valid_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_last  = last_q;

	always_comb begin
		case (k_q)
			2'd0:    ksel = SEL_S0;
			2'd1:    ksel = SEL_S1;
			default: ksel = SEL_SY;
		endcase
		cmd           = '0;
		cmd.half_bot  = bot_q;
		cmd.div_sel   = (state_q == ST_SPLIT_GO) ? SEL_SPLIT : ksel;
		cmd.load      = acc && !in_kind;
		cmd.pixel     = acc && in_kind && state_q == ST_RUN;
		cmd.div_start = state_q == ST_SPLIT_GO || (state_q == ST_DIV_GO && !sts.n_zero);
		cmd.enter     = state_q == ST_ENTER;
		cmd.start_row = state_q == ST_ROW;
		cmd.next_row  = state_q == ST_NEXT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			bot_q   <= 1'b0;
			pend_q  <= 1'b0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE, ST_RUN: begin
					if (acc && !in_kind) begin
						state_q <= ST_SORT;
						bot_q   <= 1'b0;
					end else if (cmd.pixel) begin
						state_q <= ST_SEEK;
						pend_q  <= 1'b1;
					end
				end
				ST_SORT: begin
					state_q <= sts.flat ? ST_IDLE : ST_SPLIT_GO;
				end
				ST_SPLIT_GO: begin
					state_q <= ST_SPLIT_WAIT;
				end
				ST_SPLIT_WAIT: begin
					if (sts.div_done) state_q <= ST_ENTER;
				end
				ST_ENTER: begin
					k_q     <= '0;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= sts.n_zero ? ST_SEEK : ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						if (k_q == 2'd2) begin
							state_q <= ST_ROW;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_ROW: begin
					state_q <= ST_SEEK;
				end
				ST_NEXT: begin
					state_q <= ST_ROW;
				end
				ST_SEEK: begin
					if (sts.span_left) begin
						state_q <= ST_RUN;
						valid_q <= pend_q;
						last_q  <= 1'b0;
						pend_q  <= 1'b0;
					end else if (sts.row_more) begin
						state_q <= ST_NEXT;
					end else if (!bot_q) begin
						bot_q   <= 1'b1;
						state_q <= ST_ENTER;
					end else begin
						state_q <= ST_IDLE;
						valid_q <= pend_q;
						last_q  <= 1'b1;
						pend_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/scanline_filled_triangle_unit.sv
// Top level of the scanline triangle unit: stream ports, sequencer, datapath.
// Depends on stu_pkg, stu_ctrl, stu_datapath.
//
// channel   dir  tdata                                  tuser   tlast
// s_axis    in   ax,ay,bx,by_coord,cx,cy,red,green,blue  kind    -
// m_axis    out  pixel_x,pixel_y,pixel_argb             -       last_pixel
//
// A load beat sorts the vertices, runs the split division, does the half entry, runs
// three step-size divisions on the 27-bit bit-serial divider (none for a half of zero
// extent), then does the row start and seek. A flat triangle returns to idle from sort.
// A step beat emits one pixel; it also passes through row start for each row it crosses
// and through half entry and the step-size divisions when it enters the bottom half.
// One beat is worked at a time; a beat is taken only while the output register is
// empty or draining.
// Reset clears the sequencer and the divider's control registers; other datapath registers are not reset.
module scanline_filled_triangle_unit
	import stu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // ax, ay, bx, by_coord, cx, cy, red, green, blue, pad
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pixel_x, pixel_y, pixel_argb, pad
	output logic        m_tlast
);

	cmd_t        cmd;
	sts_t        sts;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [31:0] pixel_argb;

	stu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	stu_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.ax         (s_tdata[8:0]),
		.ay         (s_tdata[16:9]),
		.bx         (s_tdata[25:17]),
		.by_coord   (s_tdata[33:26]),
		.cx         (s_tdata[42:34]),
		.cy         (s_tdata[50:43]),
		.red        (s_tdata[58:51]),
		.green      (s_tdata[66:59]),
		.blue       (s_tdata[74:67]),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_argb (pixel_argb)
	);

	assign m_tdata = {7'd0, pixel_argb, pixel_y, pixel_x};

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8:0] < 9'(SCR_W))
		else $error("pixel x beyond screen");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:9] < 8'(SCR_H))
		else $error("pixel y beyond screen");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[48:41] == ALPHA)
		else $error("alpha not opaque");

endmodule

>>> tb/scanline_filled_triangle_unit_test.sv
`timescale 1ns / 1ps
// Testbench for scanline_filled_triangle_unit: streams load and step beats, predicts
// every filled pixel in a behavioral rasterizer and compares the pixel stream.
// Depends on stu_pkg and the unit's RTL.
module scanline_filled_triangle_unit_test;
	import stu_pkg::*;

	localparam int ITEMS = 750;

	typedef enum logic [1:0] {FILL_IDLE, FILL_TOP, FILL_BOT} fill_phase_t;
	typedef enum logic {KIND_LOAD = 1'b0, KIND_STEP = 1'b1} kind_t;

	typedef struct {
		kind_t      kind;
		logic [8:0] ax, bx, cx;
		logic [7:0] ay, by_coord, cy;
		logic [7:0] red, green, blue;
	} beat_t;

	typedef struct {
		logic [8:0]  x;
		logic [7:0]  y;
		logic [31:0] argb;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	beat_t  beat_queue[$];
	pixel_t pixel_queue[$];
	beat_t  cur_beat;
	int     errors = 0;
	int     sent = 0;
	int     loads = 0;
	int     pixels_seen = 0;
	int     feed_gap = 0;
	int     drain_stall = 0;
	bit     feed_burst = 0;
	bit     drain_burst = 0;

	// rasterizer state
	fill_phase_t ph = FILL_IDLE;
	longint      vtx[6];
	longint      split_x, step_sz[3], row_i, row_n, span_x, span_i, span_n;
	bit          span_neg;
	logic [23:0] colour;

	scanline_filled_triangle_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic longint iabs(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint div_away(longint n, longint d);
		longint q;
		q = (2 * iabs(n) + d) / (2 * d);
		return n < 0 ? -q : q;
	endfunction

	function automatic longint fx_to_int(longint v);
		longint one;
		one = longint'(1) << FRAC;
		if (v >= 0) return (v + one / 2) / one;
		return -((-v + one / 2) / one);
	endfunction

	function automatic void setup_half();
		longint d0, d1, dy, n, one;
		one = longint'(1) << FRAC;
		if (ph == FILL_TOP) begin
			d0 = vtx[0] - vtx[2]; d1 = vtx[0] - split_x; dy = vtx[3] - vtx[1];
		end else begin
			d0 = split_x - vtx[4]; d1 = vtx[2] - vtx[4]; dy = vtx[5] - vtx[3];
		end
		n = iabs(d0);
		if (iabs(d1) > n) n = iabs(d1);
		if (iabs(dy) > n) n = iabs(dy);
		row_i = 0; row_n = n; span_i = 0; span_n = 0;
		if (n > 0) begin
			step_sz[0] = div_away(d0 * one, n);
			step_sz[1] = div_away(d1 * one, n);
			step_sz[2] = div_away(dy * one, n);
		end else begin
			step_sz = '{0, 0, 0};
		end
	endfunction

	function automatic void setup_row();
		longint fb, tb, fx, tx, one;
		one = longint'(1) << FRAC;
		fb = (ph == FILL_TOP ? vtx[0] : split_x) * one;
		tb = (ph == FILL_TOP ? vtx[0] : vtx[2]) * one;
		fx = fb - step_sz[0] * row_i;
		tx = tb - step_sz[1] * row_i;
		span_x = fx;
		span_neg = (tx - fx) < 0;
		span_i = 0;
		span_n = (iabs(tx - fx) + one - 1) / one;
	endfunction

	function automatic void advance_fill();
		while (ph != FILL_IDLE) begin
			if (span_i < span_n) return;
			if (row_i + 1 < row_n) begin
				row_i++;
				setup_row();
			end else if (ph == FILL_TOP) begin
				ph = FILL_BOT;
				setup_half();
				if (row_n > 0) setup_row();
			end else begin
				ph = FILL_IDLE;
			end
		end
	endfunction

	function automatic void fill_load(beat_t b);
		longint x[3], y[3], num, den, q;
		int bo, mi, tp;
		x = '{longint'(b.ax), longint'(b.bx), longint'(b.cx)};
		y = '{longint'(b.ay), longint'(b.by_coord), longint'(b.cy)};
		colour = {b.red, b.green, b.blue};
		if (y[0] >= y[1] && y[1] >= y[2]) begin bo = 0; mi = 1; tp = 2; end
		else if (y[0] >= y[2] && y[2] >= y[1]) begin bo = 0; mi = 2; tp = 1; end
		else if (y[1] >= y[0] && y[0] >= y[2]) begin bo = 1; mi = 0; tp = 2; end
		else if (y[1] >= y[2] && y[2] >= y[0]) begin bo = 1; mi = 2; tp = 0; end
		else if (y[2] >= y[0] && y[0] >= y[1]) begin bo = 2; mi = 0; tp = 1; end
		else begin bo = 2; mi = 1; tp = 0; end
		vtx = '{x[tp], y[tp], x[mi], y[mi], x[bo], y[bo]};
		den = y[bo] - y[tp];
		if (den <= 0) begin
			ph = FILL_IDLE; split_x = x[tp]; span_i = 0; span_n = 0;
			return;
		end
		num = (y[mi] - y[tp]) * (x[bo] - x[tp]);
		q = num >= 0 ? num / den : -((-num + den - 1) / den);
		split_x = x[tp] + q;
		ph = FILL_TOP;
		setup_half();
		if (row_n > 0) setup_row();
		advance_fill();
	endfunction

	function automatic bit fill_step(output pixel_t p);
		longint off, px, py, one;
		one = longint'(1) << FRAC;
		if (ph == FILL_IDLE) return 0;
		off = span_i * one;
		px = fx_to_int(span_neg ? span_x - off : span_x + off);
		py = fx_to_int((ph == FILL_TOP ? vtx[1] : vtx[3]) * one + step_sz[2] * row_i);
		if (px < 0) px = 0;
		if (px > SCR_W - 1) px = SCR_W - 1;
		if (py < 0) py = 0;
		if (py > SCR_H - 1) py = SCR_H - 1;
		p.x = px[8:0];
		p.y = py[7:0];
		p.argb = {ALPHA, colour};
		span_i++;
		advance_fill();
		p.last = ph == FILL_IDLE;
		return 1;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("pixel %0d: %s got %0h want %0h", pixels_seen, what, got, want);
		errors++;
	endtask

	// drive side
	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent++;
				if (cur_beat.kind == KIND_LOAD) begin
					fill_load(cur_beat);
					loads++;
				end else if (fill_step(p)) begin
					pixel_queue = {pixel_queue, p};
				end
			end
			if (!s_tvalid || s_tready) begin
				if (feed_gap > 0) begin
					feed_gap--;
					s_tvalid <= 1'b0;
				end else if (beat_queue.size() > 0) begin
					cur_beat = beat_queue.pop_front();
					s_tdata <= {5'd0, cur_beat.blue, cur_beat.green, cur_beat.red,
						cur_beat.cy, cur_beat.cx, cur_beat.by_coord, cur_beat.bx,
						cur_beat.ay, cur_beat.ax};
					s_tuser <= cur_beat.kind;
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 59) == 0) feed_burst = !feed_burst;
					feed_gap = feed_burst ? 0 : int'($urandom_range(0, 6));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receive side
	always @(posedge clk or negedge arst_n) begin
		pixel_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_queue.size() == 0) begin
					report("unexpected beat", m_tdata, 0);
				end else begin
					w = pixel_queue.pop_front();
					if (m_tdata[8:0] !== w.x) report("pixel_x", m_tdata[8:0], w.x);
					if (m_tdata[16:9] !== w.y) report("pixel_y", m_tdata[16:9], w.y);
					if (m_tdata[48:17] !== w.argb) report("pixel_argb", m_tdata[48:17], w.argb);
					if (m_tlast !== w.last) report("last_pixel", m_tlast, w.last);
				end
				pixels_seen++;
				if ($urandom_range(0, 59) == 0) drain_burst = !drain_burst;
				drain_stall = drain_burst ? 0 : int'($urandom_range(0, 6));
			end
			if (drain_stall > 0) begin
				drain_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic beat_t make_load(int x0, int y0, int x1, int y1, int x2, int y2);
		beat_t b;
		b.kind = KIND_LOAD;
		b.ax = 9'(x0); b.ay = 8'(y0); b.bx = 9'(x1); b.by_coord = 8'(y1);
		b.cx = 9'(x2); b.cy = 8'(y2);
		b.red = 8'($urandom); b.green = 8'($urandom); b.blue = 8'($urandom);
		return b;
	endfunction

	function automatic beat_t make_step();
		beat_t b;
		b = make_load($urandom_range(0, 319), $urandom_range(0, 239), $urandom_range(0, 319),
			$urandom_range(0, 239), $urandom_range(0, 319), $urandom_range(0, 239));
		b.kind = KIND_STEP;
		return b;
	endfunction

	function automatic void queue_beat(beat_t b);
		beat_queue = {beat_queue, b};
	endfunction

	task automatic add_steps(int n);
		repeat (n) queue_beat(make_step());
	endtask

	function automatic int near(int base, int span, int hi);
		int v;
		v = base + $urandom_range(0, span);
		return v > hi ? hi : v;
	endfunction

	initial begin
		beat_t b;
		int bx0, by0, r, queued;
		// directed
		add_steps(2);
		b = make_load(0, 0, 319, 239, 0, 239);
		b.red = 8'hFF; b.green = 8'h00; b.blue = 8'hFF;
		queue_beat(b);
		add_steps(3);
		b = make_load(319, 239, 0, 0, 319, 0);
		b.red = 8'h00; b.green = 8'hFF; b.blue = 8'h00;
		queue_beat(b);
		add_steps(2);
		queue_beat(make_load(10, 50, 200, 50, 300, 50));
		add_steps(2);
		queue_beat(make_load(100, 20, 104, 20, 102, 24));
		add_steps(6);
		queue_beat(make_load(100, 20, 104, 24, 98, 24));
		add_steps(6);
		queue_beat(make_load(5, 5, 5, 5, 5, 5));
		add_steps(1);
		queue_beat(make_load(316, 236, 319, 239, 318, 237));
		add_steps(20);
		// random
		queued = beat_queue.size();
		while (queued < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				bx0 = $urandom_range(0, 319);
				by0 = $urandom_range(0, 239);
				queue_beat(make_load(near(bx0, 7, 319), near(by0, 7, 239),
					near(bx0, 7, 319), near(by0, 7, 239), near(bx0, 7, 319),
					near(by0, 7, 239)));
				r = $urandom_range(1, 60);
			end else if (r < 95) begin
				queue_beat(make_load($urandom_range(0, 319), $urandom_range(0, 239),
					$urandom_range(0, 319), $urandom_range(0, 239), $urandom_range(0, 319),
					$urandom_range(0, 239)));
				r = $urandom_range(5, 30);
			end else begin
				r = 1;
				b = make_step();
				b.kind = kind_t'($urandom_range(0, 1));
				queue_beat(b);
				r = 0;
			end
			add_steps(r);
			queued += r + 1;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (beat_queue.size() == 0 && sent == queued);
		wait (pixel_queue.size() == 0);
		repeat (300) @(posedge clk);
		$display("ran %0d beats, %0d triangle loads, %0d pixels compared", sent, loads,
			pixels_seen);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches logged", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout with %0d beats sent, %0d pixels pending", sent, pixel_queue.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
hdl/stu_pkg.sv
hdl/stu_div.sv
hdl/stu_datapath.sv
hdl/stu_ctrl.sv
hdl/scanline_filled_triangle_unit.sv
tb/scanline_filled_triangle_unit_test.sv
